FILE: rtl/bhl_pkg.sv
// ----------------------------------------------------------------------------
// bhl_pkg
// Shared types, codes and constants for the button hold and LED pulse block.
// ----------------------------------------------------------------------------
package bhl_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] pair_hold_ms;
        logic [CFG_W-1:0] reset_hold_ms;
        logic [CFG_W-1:0] pulse_on_ms;
        logic [CFG_W-1:0] pulse_off_ms;
        logic [CFG_W-1:0] code_gap_ms;
    } t_cfg;

    typedef struct packed {
        logic       start;
        logic [2:0] count;
        logic [9:0] on_ms;
        logic [8:0] off_ms;
    } t_ack;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_STOP  = 2'd1;
    localparam logic [1:0] ACT_PAIR  = 2'd2;
    localparam logic [1:0] ACT_RESET = 2'd3;

    localparam logic [2:0] ST_BOOT   = 3'd0;
    localparam logic [2:0] ST_READY  = 3'd1;
    localparam logic [2:0] ST_SETUP  = 3'd2;
    localparam logic [2:0] ST_WIFI   = 3'd3;
    localparam logic [2:0] ST_UNCOMM = 3'd4;
    localparam logic [2:0] ST_RADIO  = 3'd5;

    localparam logic [2:0] PRESS_N   = 3'd1;
    localparam logic [9:0] PRESS_ON  = 10'd120;
    localparam logic [8:0] PRESS_OFF = 9'd120;
    localparam logic [2:0] PAIR_N    = 3'd2;
    localparam logic [9:0] PAIR_ON   = 10'd90;
    localparam logic [8:0] PAIR_OFF  = 9'd90;
    localparam logic [2:0] RESET_N   = 3'd4;
    localparam logic [9:0] RESET_ON  = 10'd600;
    localparam logic [8:0] RESET_OFF = 9'd300;

    localparam logic [2:0] REG_DEBOUNCE = 3'd0;
    localparam logic [2:0] REG_PAIR     = 3'd1;
    localparam logic [2:0] REG_RESET    = 3'd2;
    localparam logic [2:0] REG_PULSE_ON = 3'd3;
    localparam logic [2:0] REG_PULSE_OFF= 3'd4;
    localparam logic [2:0] REG_GAP      = 3'd5;

    localparam logic [CFG_W-1:0] RST_DEBOUNCE  = 16'd30;
    localparam logic [CFG_W-1:0] RST_PAIR      = 16'd3000;
    localparam logic [CFG_W-1:0] RST_RESET     = 16'd10000;
    localparam logic [CFG_W-1:0] RST_PULSE_ON  = 16'd250;
    localparam logic [CFG_W-1:0] RST_PULSE_OFF = 16'd250;
    localparam logic [CFG_W-1:0] RST_GAP       = 16'd1500;

endpackage

FILE: rtl/bhl_cfg_regs.sv
// ----------------------------------------------------------------------------
// bhl_cfg_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module bhl_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output bhl_pkg::t_cfg      o_cfg
);

    bhl_pkg::t_cfg r_cfg;
    bhl_pkg::t_cfg n_cfg;
    logic [2:0]    w_idx;
    logic          w_wr;

    assign w_idx  = paddr[4:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                bhl_pkg::REG_DEBOUNCE:  n_cfg.debounce_ms   = pwdata[15:0];
                bhl_pkg::REG_PAIR:      n_cfg.pair_hold_ms  = pwdata[15:0];
                bhl_pkg::REG_RESET:     n_cfg.reset_hold_ms = pwdata[15:0];
                bhl_pkg::REG_PULSE_ON:  n_cfg.pulse_on_ms   = pwdata[15:0];
                bhl_pkg::REG_PULSE_OFF: n_cfg.pulse_off_ms  = pwdata[15:0];
                bhl_pkg::REG_GAP:       n_cfg.code_gap_ms   = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            bhl_pkg::REG_DEBOUNCE:  prdata = {16'd0, r_cfg.debounce_ms};
            bhl_pkg::REG_PAIR:      prdata = {16'd0, r_cfg.pair_hold_ms};
            bhl_pkg::REG_RESET:     prdata = {16'd0, r_cfg.reset_hold_ms};
            bhl_pkg::REG_PULSE_ON:  prdata = {16'd0, r_cfg.pulse_on_ms};
            bhl_pkg::REG_PULSE_OFF: prdata = {16'd0, r_cfg.pulse_off_ms};
            bhl_pkg::REG_GAP:       prdata = {16'd0, r_cfg.code_gap_ms};
            default:                prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= bhl_pkg::RST_DEBOUNCE;
            r_cfg.pair_hold_ms  <= bhl_pkg::RST_PAIR;
            r_cfg.reset_hold_ms <= bhl_pkg::RST_RESET;
            r_cfg.pulse_on_ms   <= bhl_pkg::RST_PULSE_ON;
            r_cfg.pulse_off_ms  <= bhl_pkg::RST_PULSE_OFF;
            r_cfg.code_gap_ms   <= bhl_pkg::RST_GAP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: rtl/bhl_button.sv
// ----------------------------------------------------------------------------
// bhl_button
// Button debounce and hold-time classification (stop, pair, factory reset).
// ----------------------------------------------------------------------------
module bhl_button (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [31:0]        i_now,
    input  logic               i_down,
    input  bhl_pkg::t_cfg      i_cfg,
    output bhl_pkg::t_ack      o_ack,
    output logic [1:0]         o_action
);

    logic        r_held, n_held;
    logic [31:0] r_press_start, n_press_start;
    logic [31:0] r_last_edge, n_last_edge;
    logic        r_pair_cued, n_pair_cued;
    logic        r_reset_done, n_reset_done;
    logic [31:0] w_since_edge;
    logic [31:0] w_hold;

    assign w_since_edge = i_now - r_last_edge;
    assign w_hold       = i_now - r_press_start;

    always_comb begin
        n_held        = r_held;
        n_press_start = r_press_start;
        n_last_edge   = r_last_edge;
        n_pair_cued   = r_pair_cued;
        n_reset_done  = r_reset_done;
        o_ack         = '0;
        o_action      = bhl_pkg::ACT_NONE;
        if (i_down != r_held) begin
            if (w_since_edge >= {16'd0, i_cfg.debounce_ms}) begin
                n_last_edge = i_now;
                if (i_down) begin
                    n_held        = 1'b1;
                    n_press_start = i_now;
                    n_pair_cued   = 1'b0;
                    n_reset_done  = 1'b0;
                    o_ack = '{start: 1'b1, count: bhl_pkg::PRESS_N,
                              on_ms: bhl_pkg::PRESS_ON, off_ms: bhl_pkg::PRESS_OFF};
                end else begin
                    n_held = 1'b0;
                    if (!r_reset_done) begin
                        o_action = r_pair_cued ? bhl_pkg::ACT_PAIR : bhl_pkg::ACT_STOP;
                    end
                end
            end
        end else if (i_down) begin
            if (!r_pair_cued && (w_hold >= {16'd0, i_cfg.pair_hold_ms})) begin
                n_pair_cued = 1'b1;
                o_ack = '{start: 1'b1, count: bhl_pkg::PAIR_N,
                          on_ms: bhl_pkg::PAIR_ON, off_ms: bhl_pkg::PAIR_OFF};
            end else if (!r_reset_done && (w_hold >= {16'd0, i_cfg.reset_hold_ms})) begin
                n_reset_done = 1'b1;
                o_action     = bhl_pkg::ACT_RESET;
                o_ack = '{start: 1'b1, count: bhl_pkg::RESET_N,
                          on_ms: bhl_pkg::RESET_ON, off_ms: bhl_pkg::RESET_OFF};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held        <= 1'b0;
            r_press_start <= '0;
            r_last_edge   <= '0;
            r_pair_cued   <= 1'b0;
            r_reset_done  <= 1'b0;
        end else if (i_step) begin
            r_held        <= n_held;
            r_press_start <= n_press_start;
            r_last_edge   <= n_last_edge;
            r_pair_cued   <= n_pair_cued;
            r_reset_done  <= n_reset_done;
        end
    end

`ifndef SYNTHESIS
    a_reset_starts_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_action == bhl_pkg::ACT_RESET |-> o_ack.start && o_ack.count == bhl_pkg::RESET_N)
        else $error("factory reset without its acknowledgment");
`endif

endmodule

FILE: rtl/bhl_led.sv
// ----------------------------------------------------------------------------
// bhl_led
// Status priority encoder and LED pulse-code / acknowledgment sequencer.
// ----------------------------------------------------------------------------
module bhl_led (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [31:0]        i_now,
    input  logic               i_radio_ready,
    input  logic               i_setup_ap_mode,
    input  logic               i_station_connected,
    input  logic               i_commissioned,
    input  bhl_pkg::t_ack      i_ack,
    input  bhl_pkg::t_cfg      i_cfg,
    output logic               o_led,
    output logic [2:0]         o_status_code
);

    logic [2:0]  r_shown, n_shown, s_shown;
    logic [2:0]  r_pulses, n_pulses, s_pulses;
    logic        r_lit, n_lit, s_lit;
    logic [31:0] r_phase, n_phase, s_phase;
    logic        r_gap, n_gap, s_gap;
    logic [2:0]  r_ack_left, n_ack_left, s_ack_left;
    logic [9:0]  r_ack_on, n_ack_on, s_ack_on;
    logic [8:0]  r_ack_off, n_ack_off, s_ack_off;
    logic [2:0]  w_code;
    logic [31:0] w_elapsed;
    logic [15:0] w_len;

    always_comb begin
        if (!i_radio_ready)            w_code = bhl_pkg::ST_RADIO;
        else if (i_setup_ap_mode)      w_code = bhl_pkg::ST_SETUP;
        else if (!i_station_connected) w_code = bhl_pkg::ST_WIFI;
        else if (!i_commissioned)      w_code = bhl_pkg::ST_UNCOMM;
        else                           w_code = bhl_pkg::ST_READY;
    end

    // code change, then acknowledgment start
    always_comb begin
        s_shown    = r_shown;
        s_pulses   = r_pulses;
        s_lit      = r_lit;
        s_phase    = r_phase;
        s_gap      = r_gap;
        s_ack_left = r_ack_left;
        s_ack_on   = r_ack_on;
        s_ack_off  = r_ack_off;
        if (w_code != r_shown) begin
            s_shown  = w_code;
            s_pulses = 3'd0;
            s_gap    = 1'b1;
            s_phase  = i_now;
            s_lit    = 1'b0;
        end
        if (i_ack.start) begin
            s_ack_left = i_ack.count;
            s_ack_on   = i_ack.on_ms;
            s_ack_off  = i_ack.off_ms;
            s_gap      = 1'b0;
            s_lit      = 1'b1;
            s_phase    = i_now;
        end
    end

    assign w_elapsed = i_now - s_phase;

    always_comb begin
        if (s_ack_left != 3'd0) begin
            w_len = s_lit ? {6'd0, s_ack_on} : {7'd0, s_ack_off};
        end else begin
            w_len = s_lit ? i_cfg.pulse_on_ms : i_cfg.pulse_off_ms;
        end
    end

    always_comb begin
        n_shown    = s_shown;
        n_pulses   = s_pulses;
        n_lit      = s_lit;
        n_phase    = s_phase;
        n_gap      = s_gap;
        n_ack_left = s_ack_left;
        n_ack_on   = s_ack_on;
        n_ack_off  = s_ack_off;
        if (s_ack_left != 3'd0) begin
            if (w_elapsed >= {16'd0, w_len}) begin
                n_phase = i_now;
                if (s_lit) begin
                    n_lit      = 1'b0;
                    n_ack_left = s_ack_left - 3'd1;
                    if (s_ack_left == 3'd1) begin
                        n_pulses = 3'd0;
                        n_gap    = 1'b1;
                    end
                end else begin
                    n_lit = 1'b1;
                end
            end
        end else if (s_shown == bhl_pkg::ST_BOOT) begin
            n_lit = 1'b1;
        end else if (s_gap) begin
            if (w_elapsed >= {16'd0, i_cfg.code_gap_ms}) begin
                n_gap    = 1'b0;
                n_pulses = s_shown;
                n_phase  = i_now;
                n_lit    = 1'b1;
            end
        end else if (s_pulses == 3'd0) begin
            n_gap   = 1'b1;
            n_phase = i_now;
            n_lit   = 1'b0;
        end else if (w_elapsed >= {16'd0, w_len}) begin
            n_phase = i_now;
            if (s_lit) begin
                n_lit    = 1'b0;
                n_pulses = s_pulses - 3'd1;
            end else begin
                n_lit = 1'b1;
            end
        end
    end

    assign o_led         = n_lit;
    assign o_status_code = n_shown;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown    <= bhl_pkg::ST_BOOT;
            r_pulses   <= 3'd0;
            r_lit      <= 1'b1;
            r_phase    <= '0;
            r_gap      <= 1'b0;
            r_ack_left <= 3'd0;
            r_ack_on   <= '0;
            r_ack_off  <= '0;
        end else if (i_step) begin
            r_shown    <= n_shown;
            r_pulses   <= n_pulses;
            r_lit      <= n_lit;
            r_phase    <= n_phase;
            r_gap      <= n_gap;
            r_ack_left <= n_ack_left;
            r_ack_on   <= n_ack_on;
            r_ack_off  <= n_ack_off;
        end
    end

`ifndef SYNTHESIS
    a_ack_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ack_left == 3'd0 || r_ack_left == 3'd1 || r_ack_left == 3'd2 ||
        r_ack_left == 3'd3 || r_ack_left == 3'd4)
        else $error("acknowledgment count out of range");
`endif

endmodule

FILE: rtl/button_hold_and_led_pulse_code.sv
// ----------------------------------------------------------------------------
// button_hold_and_led_pulse_code
// Button hold classifier and status LED pulse-code indicator.
// ----------------------------------------------------------------------------
// Usage:
// Each slave-side transfer is one sample: millisecond timestamp, button level
// and four health flags. Each sample yields exactly one master-side transfer
// with the LED drive, the button action of that sample and the status code.
// A sample is held in an input register, worked through the status encoder,
// button classifier and LED sequencer combinationally, and the result lands
// in an output register. Throughput is one sample per cycle while the
// receiver takes results; o_s_tready stays high while the output register
// is empty or being taken. When the receiver stalls, one result and one
// sample wait in the two registers and o_s_tready falls. Reset restores the
// register defaults, clears the button state and puts the LED in the booting
// state (lit). Registers are written over the APB port; the user must write
// them only while no sample is in flight, as the block does not enforce it.
// ----------------------------------------------------------------------------
module button_hold_and_led_pulse_code (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // [31:0] now_ms, [32] button_down, [33] radio_ready, [34] setup_ap_mode,
    // [35] station_connected, [36] commissioned, [39:37] zero
    input  logic [39:0] i_s_tdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [0] led, [2:1] action, [5:3] status_code, [7:6] zero
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic          r_in_valid;
    logic [36:0]   r_in_data;
    logic          r_out_valid;
    logic [5:0]    r_out_data;
    logic          w_move;
    logic          w_led;
    logic [1:0]    w_action;
    logic [2:0]    w_status;
    bhl_pkg::t_cfg w_cfg;
    bhl_pkg::t_ack w_ack;

    assign w_move     = r_in_valid & (~r_out_valid | i_m_tready);
    assign o_s_tready = ~r_in_valid | w_move;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_data};

    bhl_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bhl_button u_button (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_move),
        .i_now    (r_in_data[31:0]),
        .i_down   (r_in_data[32]),
        .i_cfg    (w_cfg),
        .o_ack    (w_ack),
        .o_action (w_action)
    );

    bhl_led u_led (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_step              (w_move),
        .i_now               (r_in_data[31:0]),
        .i_radio_ready       (r_in_data[33]),
        .i_setup_ap_mode     (r_in_data[34]),
        .i_station_connected (r_in_data[35]),
        .i_commissioned      (r_in_data[36]),
        .i_ack               (w_ack),
        .i_cfg               (w_cfg),
        .o_led               (w_led),
        .o_status_code       (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= (i_s_tvalid & o_s_tready) | (r_in_valid & ~w_move);
            r_out_valid <= w_move | (r_out_valid & ~i_m_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid & o_s_tready) begin
            r_in_data <= i_s_tdata[36:0];
        end
        if (w_move) begin
            r_out_data <= {w_status, w_action, w_led};
        end
    end

`ifndef SYNTHESIS
    a_stalled_sample_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_move |=> r_in_valid && $stable(r_in_data))
        else $error("waiting sample lost or changed");

    a_move_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> r_out_valid)
        else $error("processed sample produced no result");

    a_reset_lights_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[2:1] == bhl_pkg::ACT_RESET |-> r_out_data[0])
        else $error("factory reset result with LED dark");
`endif

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the button hold classifier and LED pulse-code block.
// Samples go in on the slave stream. A predictor runs each transfer and queues
// the expected LED drive, button action and status code, and every result
// transfer is checked against the oldest entry. Covered: a directed run
// through each status code, debounce, stop, pair and factory reset and time
// wrap; press-and-hold sequences under register extremes; four phases of
// sender and receiver idling; and a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

    // flag nibble: [0] radio_ready, [1] setup_ap_mode, [2] station_connected,
    // [3] commissioned
    localparam logic [3:0] FL_READY    = 4'b1101;
    localparam logic [3:0] FL_NO_RADIO = 4'b1100;
    localparam logic [3:0] FL_SETUP    = 4'b1111;
    localparam logic [3:0] FL_WIFI     = 4'b1001;
    localparam logic [3:0] FL_UNCOMM   = 4'b0101;

    typedef struct packed {
        logic        commissioned;
        logic        connected;
        logic        ap_mode;
        logic        radio;
        logic        down;
        logic [31:0] now;
    } t_sample;

    typedef struct packed {
        logic [2:0] code;
        logic [1:0] act;
        logic       led;
    } t_result;

    typedef struct packed {
        logic [2:0]  shown;
        logic [2:0]  pulses;
        logic        lit;
        logic [31:0] phase_t;
        logic        gap;
        logic [2:0]  ack_n;
        logic [9:0]  ack_on;
        logic [8:0]  ack_off;
        logic        held;
        logic [31:0] press_t;
        logic [31:0] last_edge_t;
        logic        cued;
        logic        fired;
    } t_led_state;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic [39:0] i_s_tdata  = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  o_m_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [4:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;

    bhl_pkg::t_cfg model_cfg;
    t_led_state  st;
    t_result     expected_results[$];
    t_result     got_r;
    t_result     want_r;
    int          mismatch_count = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned stall_pct      = 0;
    int unsigned hold_cycles    = 0;
    logic [31:0] now_t          = '0;
    logic [3:0]  cur_flags      = FL_READY;

    button_hold_and_led_pulse_code dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void start_flash(input logic [2:0] n, input logic [9:0] on_ms,
                                        input logic [8:0] off_ms, input logic [31:0] t);
        st.ack_n   = n;
        st.ack_on  = on_ms;
        st.ack_off = off_ms;
        st.gap     = 1'b0;
        st.lit     = 1'b1;
        st.phase_t = t;
    endfunction

    function automatic t_result predict_led_action(input t_sample s);
        t_result     r;
        logic [2:0]  code;
        logic [31:0] dt;
        logic [31:0] len_ms;
        r.act = bhl_pkg::ACT_NONE;
        if (!s.radio) code = bhl_pkg::ST_RADIO;
        else if (s.ap_mode) code = bhl_pkg::ST_SETUP;
        else if (!s.connected) code = bhl_pkg::ST_WIFI;
        else if (!s.commissioned) code = bhl_pkg::ST_UNCOMM;
        else code = bhl_pkg::ST_READY;
        if (code != st.shown) begin
            st.shown   = code;
            st.pulses  = 3'd0;
            st.gap     = 1'b1;
            st.phase_t = s.now;
            st.lit     = 1'b0;
        end

        if (s.down != st.held) begin
            dt = s.now - st.last_edge_t;
            if (dt >= {16'd0, model_cfg.debounce_ms}) begin
                st.last_edge_t = s.now;
                if (s.down) begin
                    st.held    = 1'b1;
                    st.press_t = s.now;
                    st.cued    = 1'b0;
                    st.fired   = 1'b0;
                    start_flash(bhl_pkg::PRESS_N, bhl_pkg::PRESS_ON,
                                bhl_pkg::PRESS_OFF, s.now);
                end else begin
                    st.held = 1'b0;
                    if (!st.fired) r.act = st.cued ? bhl_pkg::ACT_PAIR : bhl_pkg::ACT_STOP;
                end
            end
        end else if (s.down) begin
            dt = s.now - st.press_t;
            if (!st.cued && dt >= {16'd0, model_cfg.pair_hold_ms}) begin
                st.cued = 1'b1;
                start_flash(bhl_pkg::PAIR_N, bhl_pkg::PAIR_ON, bhl_pkg::PAIR_OFF, s.now);
            end else if (!st.fired && dt >= {16'd0, model_cfg.reset_hold_ms}) begin
                st.fired = 1'b1;
                start_flash(bhl_pkg::RESET_N, bhl_pkg::RESET_ON, bhl_pkg::RESET_OFF, s.now);
                r.act = bhl_pkg::ACT_RESET;
            end
        end

        dt = s.now - st.phase_t;
        if (st.ack_n != 3'd0) begin
            len_ms = st.lit ? {22'd0, st.ack_on} : {23'd0, st.ack_off};
            if (dt >= len_ms) begin
                st.phase_t = s.now;
                if (st.lit) begin
                    st.lit   = 1'b0;
                    st.ack_n = st.ack_n - 3'd1;
                    if (st.ack_n == 3'd0) begin
                        st.pulses = 3'd0;
                        st.gap    = 1'b1;
                    end
                end else begin
                    st.lit = 1'b1;
                end
            end
        end else if (st.shown == bhl_pkg::ST_BOOT) begin
            st.lit = 1'b1;
        end else if (st.gap) begin
            if (dt >= {16'd0, model_cfg.code_gap_ms}) begin
                st.gap     = 1'b0;
                st.pulses  = st.shown;
                st.phase_t = s.now;
                st.lit     = 1'b1;
            end
        end else if (st.pulses == 3'd0) begin
            st.gap     = 1'b1;
            st.phase_t = s.now;
            st.lit     = 1'b0;
        end else begin
            len_ms = st.lit ? {16'd0, model_cfg.pulse_on_ms} : {16'd0, model_cfg.pulse_off_ms};
            if (dt >= len_ms) begin
                st.phase_t = s.now;
                if (st.lit) begin
                    st.lit    = 1'b0;
                    st.pulses = st.pulses - 3'd1;
                end else begin
                    st.lit = 1'b1;
                end
            end
        end

        r.led  = st.lit;
        r.code = st.shown;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_sample(input t_sample s);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, s};
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        expected_results.push_back(predict_led_action(s));
    endtask

    task automatic next_at(input logic [31:0] t, input logic d, input logic [3:0] f);
        now_t     = t;
        cur_flags = f;
        send_sample({f, d, t});
    endtask

    task automatic next_sample(input logic d, input int unsigned delta);
        now_t = now_t + delta;
        if ($urandom_range(0, 19) == 0)
            cur_flags = $urandom_range(0, 1) ? FL_READY : 4'($urandom_range(0, 15));
        send_sample({cur_flags, d, now_t});
    endtask

    function automatic int unsigned rand_step(input int unsigned step_max);
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 3);
        return $urandom_range(1, step_max);
    endfunction

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            bhl_pkg::REG_DEBOUNCE:  model_cfg.debounce_ms   = value;
            bhl_pkg::REG_PAIR:      model_cfg.pair_hold_ms  = value;
            bhl_pkg::REG_RESET:     model_cfg.reset_hold_ms = value;
            bhl_pkg::REG_PULSE_ON:  model_cfg.pulse_on_ms   = value;
            bhl_pkg::REG_PULSE_OFF: model_cfg.pulse_off_ms  = value;
            bhl_pkg::REG_GAP:       model_cfg.code_gap_ms   = value;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_all(input logic [15:0] deb, input logic [15:0] pair,
                             input logic [15:0] rst, input logic [15:0] on_ms,
                             input logic [15:0] off_ms, input logic [15:0] gap_ms);
        wait_idle();
        write_reg(bhl_pkg::REG_DEBOUNCE, deb);
        write_reg(bhl_pkg::REG_PAIR, pair);
        write_reg(bhl_pkg::REG_RESET, rst);
        write_reg(bhl_pkg::REG_PULSE_ON, on_ms);
        write_reg(bhl_pkg::REG_PULSE_OFF, off_ms);
        write_reg(bhl_pkg::REG_GAP, gap_ms);
    endtask

    // idle, press, hold for a short, middle or long time, release; plus noise
    task automatic run_gestures(input int n, input int unsigned step_max);
        int          sent;
        int unsigned hold_ms;
        int unsigned elapsed;
        int unsigned step;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 99) < 15) begin
                if ($urandom_range(0, 7) == 0) now_t = $urandom();
                next_sample($urandom_range(0, 1), $urandom_range(0, 40));
                sent++;
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    next_sample(1'b0, rand_step(step_max));
                    sent++;
                end
                case ($urandom_range(0, 2))
                    0: hold_ms = $urandom_range(0, model_cfg.pair_hold_ms);
                    1: hold_ms = $urandom_range(model_cfg.pair_hold_ms,
                                                model_cfg.reset_hold_ms);
                    default: hold_ms = model_cfg.reset_hold_ms + $urandom_range(0, 3000);
                endcase
                next_sample(1'b1, rand_step(step_max));
                sent++;
                elapsed = 0;
                while (elapsed < hold_ms) begin
                    step = rand_step(step_max);
                    elapsed += step;
                    next_sample(1'b1, step);
                    sent++;
                end
                next_sample(1'b0, rand_step(step_max));
                sent++;
            end
        end
    endtask

    task automatic test_directed();
        next_at(32'd0, 1'b0, FL_NO_RADIO);
        next_at(32'd5, 1'b0, FL_SETUP);
        next_at(32'd9, 1'b0, FL_WIFI);
        next_at(32'd12, 1'b0, FL_UNCOMM);
        next_at(32'd16, 1'b0, FL_READY);
        next_at(32'd40, 1'b1, FL_READY);
        next_at(32'd55, 1'b0, FL_READY);
        next_at(32'd300, 1'b0, FL_READY);
        next_at(32'd320, 1'b1, FL_READY);
        next_at(32'd400, 1'b1, FL_READY);
        next_at(32'd2000, 1'b1, FL_READY);
        next_at(32'd3400, 1'b1, FL_READY);
        next_at(32'd3500, 1'b0, FL_READY);
        next_at(32'd3600, 1'b1, FL_READY);
        next_at(32'd6600, 1'b1, FL_READY);
        next_at(32'd13600, 1'b1, FL_READY);
        next_at(32'd14000, 1'b1, FL_READY);
        next_at(32'd14100, 1'b0, FL_READY);
        next_at(32'd14200, 1'b1, FL_NO_RADIO);
        next_at(32'd14300, 1'b0, FL_READY);
        next_at(32'hFFFF_FF00, 1'b1, FL_READY);
        next_at(32'h0000_0100, 1'b1, FL_READY);
        next_at(32'hFFFF_FFFF, 1'b0, FL_SETUP);
        next_at(32'hFFFF_FFFF, 1'b1, FL_UNCOMM);
        next_at(32'h0000_1000, 1'b0, FL_READY);
    endtask

    task automatic test_register_extremes();
        write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_gestures(100, 50);
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_gestures(100, 9000);
        write_all(16'd0, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF, 16'd1);
        run_gestures(60, 3000);
    endtask

    task automatic test_flow_phases();
        write_all(16'd20, 16'd1500, 16'd4000, 16'd100, 16'd150, 16'd600);
        send_idle_pct = 0;
        stall_pct     = 0;
        run_gestures(250, 300);
        send_idle_pct = 75;
        run_gestures(250, 300);
        send_idle_pct = 0;
        stall_pct     = 75;
        run_gestures(250, 300);
        send_idle_pct = 23;
        stall_pct     = 23;
        run_gestures(250, 300);
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    task automatic test_backpressure();
        hold_cycles = 200;
        repeat (40) next_sample($urandom_range(0, 1), rand_step(200));
    endtask

    initial begin
        model_cfg = {bhl_pkg::RST_DEBOUNCE, bhl_pkg::RST_PAIR, bhl_pkg::RST_RESET,
                     bhl_pkg::RST_PULSE_ON, bhl_pkg::RST_PULSE_OFF, bhl_pkg::RST_GAP};
        st        = '0;
        st.lit    = 1'b1;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_register_extremes();
        test_flow_phases();
        test_backpressure();

        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("button_hold_and_led_pulse_code test passed");
        end else begin
            $display("button_hold_and_led_pulse_code test failed");
        end
        $finish;
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_r = o_m_tdata[5:0];
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected", got_r, 0);
            end else begin
                want_r = expected_results.pop_front();
                if (got_r.led != want_r.led)
                    report_mismatch("led", got_r.led, want_r.led);
                if (got_r.act != want_r.act)
                    report_mismatch("action", got_r.act, want_r.act);
                if (got_r.code != want_r.code)
                    report_mismatch("status_code", got_r.code, want_r.code);
            end
        end
    end

    initial begin
        #8_000_000;
        $display("button_hold_and_led_pulse_code test failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/bhl_pkg.sv
rtl/bhl_cfg_regs.sv
rtl/bhl_button.sv
rtl/bhl_led.sv
rtl/button_hold_and_led_pulse_code.sv
tb/sv/testbench.sv
